FILE: src/mmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared constants, state encoding and divider handshake types for the
// min/max normaliser.
// ----------------------------------------------------------------------------
package mmn_pkg;

   localparam int MAX_LEN    = 64;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_LEN + 1);
   localparam int SAMPLE_W   = 16;
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_DATA,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [2*SAMPLE_W-1:0] dividend;
      logic [SAMPLE_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: src/mmn_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_store
// Sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmn_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mmn_pkg::ADDR_W-1:0]        wr_addr,
   input  logic [mmn_pkg::SAMPLE_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [mmn_pkg::ADDR_W-1:0]        rd_addr,
   output logic [mmn_pkg::SAMPLE_W-1:0]      rd_data
);

   logic [mmn_pkg::SAMPLE_W-1:0] mem_ff [mmn_pkg::MAX_LEN];
   logic [mmn_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mmn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_divider
// Restoring divider, one quotient bit per cycle. The dividend's upper half
// must be below the divisor so that the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module mmn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mmn_pkg::div_req_type req,
   output mmn_pkg::div_rsp_type rsp
);

   logic [mmn_pkg::SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [mmn_pkg::SAMPLE_W-1:0]  low_ff, low_in;
   logic [mmn_pkg::SAMPLE_W-1:0]  divisor_ff;
   logic [mmn_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          active_ff;
   logic                          done_ff;
   logic [mmn_pkg::SAMPLE_W:0]    shifted;
   logic [mmn_pkg::SAMPLE_W:0]    diff;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff, low_ff[mmn_pkg::SAMPLE_W-1]};
      ge      = shifted >= {1'b0, divisor_ff};
      diff    = shifted - {1'b0, divisor_ff};
      // partial remainder stays below the divisor
      rem_in  = ge ? diff[mmn_pkg::SAMPLE_W-1:0] : shifted[mmn_pkg::SAMPLE_W-1:0];
      low_in  = {low_ff[mmn_pkg::SAMPLE_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            active_ff <= 1'b1;
            cnt_ff    <= mmn_pkg::DIV_CNT_W'(mmn_pkg::DIV_STEPS);
         end else if (active_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == mmn_pkg::DIV_CNT_W'(1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff     <= req.dividend[2*mmn_pkg::SAMPLE_W-1:mmn_pkg::SAMPLE_W];
         low_ff     <= req.dividend[mmn_pkg::SAMPLE_W-1:0];
         divisor_ff <= req.divisor;
      end else if (active_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = low_ff;

endmodule

FILE: src/min_max_normalizer.sv
`timescale 1ns / 1ps
// load: one sample a cycle, busy low; an item with last_in raised starts the emit pass
// emit: per result, a memory read, operand set-up, a bit-serial divide and a strobe, in that order
// rsp_valid is a one-cycle strobe and the receiver cannot stall it
// synchronous active-high reset empties the run: min/max to extremes, count to zero
// ----------------------------------------------------------------------------
// min_max_normalizer
// Stores a vector of signed samples, tracks min and max, then emits each
// sample scaled to an unsigned 16-bit fraction of the observed range.
// ----------------------------------------------------------------------------
module min_max_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [mmn_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   output logic [mmn_pkg::SAMPLE_W-1:0]      rsp_scaled,
   output logic                              rsp_flat,
   output logic                              rsp_last_out
);

   mmn_pkg::state_type state_ff, state_in;

   logic [mmn_pkg::CNT_W-1:0]           fill_ff, fill_in;
   logic [mmn_pkg::CNT_W-1:0]           idx_ff, idx_in;
   logic signed [mmn_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [mmn_pkg::SAMPLE_W-1:0] max_ff, max_in;

   logic                         accept;
   logic                         room;
   logic                         flat;
   logic                         final_res;
   logic                         rd_en;
   logic [mmn_pkg::SAMPLE_W-1:0] rd_data;
   logic [mmn_pkg::SAMPLE_W-1:0] span;
   logic [mmn_pkg::SAMPLE_W-1:0] offset;
   mmn_pkg::div_req_type         div_req;
   mmn_pkg::div_rsp_type         div_rsp;

   assign accept    = start && (state_ff == mmn_pkg::ST_LOAD);
   assign room      = fill_ff < mmn_pkg::CNT_W'(mmn_pkg::MAX_LEN);
   assign flat      = max_ff <= min_ff;
   assign final_res = (idx_ff + 1'b1) == fill_ff;

   mmn_store u_store (
      .clock   (clock),
      .wr_en   (accept && room),
      .wr_addr (fill_ff[mmn_pkg::ADDR_W-1:0]),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[mmn_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // span is 1 on a flat run, where every offset is zero anyway
   always_comb begin
      span             = flat ? mmn_pkg::SAMPLE_W'(1) : max_ff - min_ff;
      offset           = rd_data - min_ff;
      div_req.start    = state_ff == mmn_pkg::ST_DATA;
      div_req.dividend = {offset, {mmn_pkg::SAMPLE_W{1'b0}}}
                       - {{mmn_pkg::SAMPLE_W{1'b0}}, offset};
      div_req.divisor  = span;
   end

   mmn_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmn_pkg::ST_LOAD: begin
            if (accept && req_last_in) begin
               state_in = mmn_pkg::ST_READ;
            end
         end
         mmn_pkg::ST_READ: state_in = mmn_pkg::ST_DATA;
         mmn_pkg::ST_DATA: state_in = mmn_pkg::ST_DIV;
         mmn_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = mmn_pkg::ST_EMIT;
            end
         end
         mmn_pkg::ST_EMIT: begin
            state_in = final_res ? mmn_pkg::ST_LOAD : mmn_pkg::ST_READ;
         end
         default: state_in = mmn_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      rd_en     = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         mmn_pkg::ST_LOAD: busy      = 1'b0;
         mmn_pkg::ST_READ: rd_en     = 1'b1;
         mmn_pkg::ST_DATA: busy      = 1'b1;
         mmn_pkg::ST_DIV:  busy      = 1'b1;
         mmn_pkg::ST_EMIT: rsp_valid = 1'b1;
         default:          busy      = 1'b1;
      endcase
   end

   assign rsp_scaled   = div_rsp.quotient;
   assign rsp_flat     = flat;
   assign rsp_last_out = final_res;

   // run statistics
   always_comb begin
      fill_in = fill_ff;
      idx_in  = idx_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (accept) begin
         idx_in = '0;
         if (room) begin
            fill_in = fill_ff + 1'b1;
            if (req_sample < min_ff) begin
               min_in = req_sample;
            end
            if (req_sample > max_ff) begin
               max_in = req_sample;
            end
         end
      end else if (state_ff == mmn_pkg::ST_EMIT) begin
         if (final_res) begin
            fill_in = '0;
            idx_in  = '0;
            min_in  = mmn_pkg::MIN_RESET;
            max_in  = mmn_pkg::MAX_RESET;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmn_pkg::ST_LOAD;
         fill_ff  <= '0;
         idx_ff   <= '0;
         min_ff   <= mmn_pkg::MIN_RESET;
         max_ff   <= mmn_pkg::MAX_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

endmodule

FILE: src/mmn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_checker
// Port-level checks on the normaliser's command and strobe behaviour.
// ----------------------------------------------------------------------------
module mmn_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_last_in,
   input logic                         rsp_valid,
   input logic [mmn_pkg::SAMPLE_W-1:0] rsp_scaled,
   input logic                         rsp_flat,
   input logic                         rsp_last_out
);

   // no result while the block is taking samples
   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid)
      else $error("result strobe while not busy");

   // results are spaced by the divider, never in adjacent cycles
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in adjacent cycles");

   // a flat run scales every beat to zero
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flat) |-> (rsp_scaled == '0))
      else $error("flat run with non-zero result");

   // the final sample beat starts the emit pass
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_in) |=> busy)
      else $error("not busy after final sample");

   // the final result ends the emit pass
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |=> !busy)
      else $error("still busy after final result");

endmodule

bind min_max_normalizer mmn_checker u_mmn_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_last_in  (req_last_in),
   .rsp_valid    (rsp_valid),
   .rsp_scaled   (rsp_scaled),
   .rsp_flat     (rsp_flat),
   .rsp_last_out (rsp_last_out)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the min/max normaliser. Vectors of signed samples are sent as beats,
// and an in-bench predictor normalises each finished vector. Every result
// strobe is compared field by field with the oldest expected result. Directed
// vectors come first, then random vectors under several sender idling mixes.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [mmn_pkg::SAMPLE_W-1:0] scaled;
      logic                         flat;
      logic                         last_out;
   } norm_beat_type;

   typedef enum int {
      VK_WIDE,
      VK_NARROW,
      VK_FLAT,
      VK_EXTREME
   } vec_kind_type;

   localparam int TAIL_CYCLES = 40;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [mmn_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                req_last_in = 1'b0;
   logic                                rsp_valid;
   logic [mmn_pkg::SAMPLE_W-1:0]        rsp_scaled;
   logic                                rsp_flat;
   logic                                rsp_last_out;

   // predictor state for the vector being collected
   logic signed [mmn_pkg::SAMPLE_W-1:0] vec_store [mmn_pkg::MAX_LEN];
   int                                  vec_lo;
   int                                  vec_hi;
   int                                  vec_fill;

   norm_beat_type pending_norms[$];
   int            mismatches = 0;
   int            beats_sent = 0;

   min_max_normalizer dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample   (req_sample),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_scaled   (rsp_scaled),
      .rsp_flat     (rsp_flat),
      .rsp_last_out (rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_vector();
      vec_lo   = 32767;
      vec_hi   = -32768;
      vec_fill = 0;
   endfunction

   // store the sample, track the range, and on the final beat queue the scaled vector
   function automatic void absorb_sample(input logic signed [mmn_pkg::SAMPLE_W-1:0] x,
                                         input logic last);
      int            span;
      longint        d;
      longint        q;
      logic          is_flat;
      norm_beat_type r;
      if (vec_fill < mmn_pkg::MAX_LEN) begin
         vec_store[vec_fill] = x;
         vec_fill++;
         if (int'(x) < vec_lo) vec_lo = int'(x);
         if (int'(x) > vec_hi) vec_hi = int'(x);
      end
      if (last) begin
         is_flat = (vec_hi <= vec_lo);
         span    = is_flat ? 1 : vec_hi - vec_lo;
         for (int k = 0; k < vec_fill; k++) begin
            q = 0;
            if (!is_flat) begin
               d = longint'((int'(vec_store[k]) - vec_lo) & 32'hFFFF);
               q = (d * 65535) / span;
               if (q > 65535) q = 65535;
            end
            r.scaled   = q[mmn_pkg::SAMPLE_W-1:0];
            r.flat     = is_flat;
            r.last_out = (k == vec_fill - 1);
            pending_norms.push_back(r);
         end
         clear_vector();
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      norm_beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_norms.size() == 0) begin
            report_mismatch("unexpected result, scaled", int'(rsp_scaled), -1);
         end else begin
            want = pending_norms.pop_front();
            if (rsp_scaled !== want.scaled)
               report_mismatch("scaled", int'(rsp_scaled), int'(want.scaled));
            if (rsp_flat !== want.flat)
               report_mismatch("flat", int'(rsp_flat), int'(want.flat));
            if (rsp_last_out !== want.last_out)
               report_mismatch("last_out", int'(rsp_last_out), int'(want.last_out));
         end
      end
   end

   // start stays high across back-to-back beats; only a gap or a drain lowers it
   task automatic send_beat(input logic signed [mmn_pkg::SAMPLE_W-1:0] x,
                            input logic last);
      @(negedge clock);
      start       = 1'b1;
      req_sample  = x;
      req_last_in = last;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_sample(x, last);
      beats_sent++;
   endtask

   task automatic sender_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // hold off until every queued result has come out
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      wait (pending_norms.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_vector(input int len, input vec_kind_type kind, input int idle_pct);
      logic signed [mmn_pkg::SAMPLE_W-1:0] base;
      logic signed [mmn_pkg::SAMPLE_W-1:0] x;
      int                                  spread;
      base   = mmn_pkg::SAMPLE_W'($urandom);
      spread = $urandom_range(1, 400);
      for (int i = 0; i < len; i++) begin
         case (kind)
            VK_WIDE:   x = mmn_pkg::SAMPLE_W'($urandom);
            VK_NARROW: x = base + mmn_pkg::SAMPLE_W'($urandom_range(0, spread));
            VK_FLAT:   x = base;
            default: begin
               case ($urandom_range(3))
                  0: x = 16'sh8000;
                  1: x = 16'sh7FFF;
                  2: x = 16'sh0000;
                  default: x = mmn_pkg::SAMPLE_W'($urandom);
               endcase
            end
         endcase
         sender_gap(idle_pct);
         send_beat(x, i == len - 1);
      end
   endtask

   task automatic test_extremes();
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh0000, 1'b0);
      send_beat(-16'sd1, 1'b0);
      send_beat(16'sd1, 1'b0);
      send_beat(16'sh4000, 1'b1);
      // smallest non-zero span
      send_beat(16'sd100, 1'b0);
      send_beat(16'sd101, 1'b1);
      // minimum in the middle of the vector
      send_beat(-16'sd3, 1'b0);
      send_beat(-16'sd5, 1'b0);
      send_beat(-16'sd4, 1'b1);
   endtask

   task automatic test_flat_vectors();
      send_beat(16'sd7, 1'b0);
      send_beat(16'sd7, 1'b0);
      send_beat(16'sd7, 1'b1);
      send_beat(16'sh8000, 1'b1);
      send_beat(16'sh7FFF, 1'b1);
   endtask

   // beats beyond the store depth are dropped; the last one still triggers the emit
   task automatic test_store_full();
      for (int i = 0; i < mmn_pkg::MAX_LEN + 2; i++)
         send_beat(mmn_pkg::SAMPLE_W'($urandom), i == mmn_pkg::MAX_LEN + 1);
      drain_results();
   endtask

   task automatic run_random_phase(input int idle_pct, input int goal);
      int stop_at;
      int pick;
      int len;
      stop_at = beats_sent + goal;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70)      len = $urandom_range(1, 12);
         else if (pick < 92) len = $urandom_range(13, 40);
         else                len = $urandom_range(mmn_pkg::MAX_LEN - 4, mmn_pkg::MAX_LEN + 4);
         send_vector(len, vec_kind_type'($urandom_range(3)), idle_pct);
      end
      drain_results();
   endtask

   task automatic test_random_back_to_back();
      run_random_phase(0, 40);
   endtask

   task automatic test_random_sparse();
      run_random_phase(79, 40);
   endtask

   task automatic test_random_light_gaps();
      run_random_phase(16, 40);
   endtask

   initial begin
      clear_vector();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_flat_vectors();
      drain_results();
      test_store_full();
      test_random_back_to_back();
      test_random_sparse();
      test_random_light_gaps();

      @(negedge clock);
      start = 1'b0;
      wait (pending_norms.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/mmn_pkg.sv
src/mmn_store.sv
src/mmn_divider.sv
src/min_max_normalizer.sv
src/mmn_checker.sv
tb/tb.sv
